FILE: rtl/bps_pkg.sv
// Shared types, constants and helpers of the byte pattern scrubber.
`timescale 1ns / 1ps

package bps_pkg;

    localparam int MAX_PATTERN_DEF = 24;
    localparam int PATTERN_BYTES   = 24;
    localparam int BYTE_W          = 8;
    localparam int LENGTH_W        = 5;
    localparam int WORD_W          = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL         = 3'd4;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd1;
    localparam logic [BYTE_W-1:0]   BYTE_ZERO    = 8'h00;

    typedef struct packed {
        logic [WORD_W-1:0]   pattern_low;
        logic [WORD_W-1:0]   pattern_mid;
        logic [WORD_W-1:0]   pattern_high;
        logic [LENGTH_W-1:0] length;
        logic [BYTE_W-1:0]   fill;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } emit_t;

    // Pattern byte i; bytes past the three words compare as zero.
    function automatic logic [BYTE_W-1:0] pattern_byte(input cfg_t c, input int i);
        logic [PATTERN_BYTES*BYTE_W-1:0] all;
        all = {c.pattern_high, c.pattern_mid, c.pattern_low};
        if (i >= PATTERN_BYTES) begin
            return BYTE_ZERO;
        end
        return all[i*BYTE_W +: BYTE_W];
    endfunction

endpackage

FILE: rtl/bps_if.sv
// Stream interfaces of the byte pattern scrubber: raw bytes in, scrubbed bytes out.
`timescale 1ns / 1ps

interface bps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface bps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/byte_pattern_scrubber_unit.sv
// Top level of the byte pattern scrubber: input stage, match window and output register.
`timescale 1ns / 1ps

// Streaming search and replace over a byte stream. Each beat on ingress carries one byte;
// the block keeps the last pattern_length bytes in a window, and whenever the window fills
// it compares them with the configured pattern and, on a match, overwrites all of them
// with fill_byte before the oldest byte leaves on egress. Later compares see the replaced
// bytes. A beat with end_of_stream set flushes the window, and the final byte of the
// stream goes out with out_last. Throughput is one byte per cycle in steady state while
// egress takes every byte: a one-entry input stage feeds a combinational compare into one
// output register, so a new beat is taken while the previous result still waits on egress.
// The window shift register moves at most one byte out per cycle, so a stream end drains
// each byte still held (up to pattern_length - 1) before the next beat is consumed, and
// surplus held bytes leave first after pattern_length is lowered. Ingress beats pass the
// input stage, then the output register. Write configuration only while idle.

module byte_pattern_scrubber_unit
#(
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    bps_in_if.sink                          ingress,
    bps_out_if.source                       egress
);
    import bps_pkg::*;

    cfg_t  cfg;
    item_t pend_item_reg;
    logic  pend_reg;
    logic  pend_next;
    logic  in_beat;
    logic  consume;
    logic  out_free;
    emit_t emit;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    bps_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bps_window #(.MAX_PATTERN(MAX_PATTERN)) u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (pend_reg),
        .item       (pend_item_reg),
        .out_free   (out_free),
        .consume    (consume),
        .emit       (emit)
    );

    // Input stage: take a new beat when empty or when the held one is used up this cycle.
    assign ingress.ready = !pend_reg || consume;
    assign in_beat       = ingress.valid && ingress.ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat)
        begin
            pend_next = 1'b1;
        end
        else if (consume)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pend_item_reg.data_byte     <= ingress.data_byte;
            pend_item_reg.end_of_stream <= ingress.end_of_stream;
        end
    end

    // Output register: free when empty or when its beat goes out this cycle.
    assign out_free = !out_valid_reg || egress.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit.valid)
        begin
            out_byte_reg <= emit.data;
            out_last_reg <= emit.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign egress.valid    = out_valid_reg;
    assign egress.out_byte = out_byte_reg;
    assign egress.out_last = out_last_reg;

endmodule

FILE: rtl/bps_cfg_regs.sv
// Configuration registers of the byte pattern scrubber.
`timescale 1ns / 1ps

module bps_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bps_pkg::cfg_t                    cfg
);
    import bps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  cfg_next.pattern_low  = cfg_data[WORD_W-1:0];
                REG_PATTERN_MID:  cfg_next.pattern_mid  = cfg_data[WORD_W-1:0];
                REG_PATTERN_HIGH: cfg_next.pattern_high = cfg_data[WORD_W-1:0];
                REG_LENGTH:       cfg_next.length       = cfg_data[LENGTH_W-1:0];
                REG_FILL:         cfg_next.fill         = cfg_data[BYTE_W-1:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low  <= '0;
            cfg_reg.pattern_mid  <= '0;
            cfg_reg.pattern_high <= '0;
            cfg_reg.length       <= LENGTH_RESET;
            cfg_reg.fill         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/bps_window.sv
// Match window: shift register of recent bytes, parallel compare, fill and flush control.
`timescale 1ns / 1ps

module bps_window
#(
    parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  bps_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  bps_pkg::item_t item,
    input  logic           out_free,
    output logic           consume,
    output bps_pkg::emit_t emit
);
    import bps_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int LW    = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

    logic [BYTE_W-1:0]      win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]      win_next [MAX_PATTERN];
    logic [BYTE_W-1:0]      app      [MAX_PATTERN];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   flush_reg;
    logic                   flush_next;
    logic [LW-1:0]          len_raw;
    logic [CNT_W-1:0]       len;
    logic [MAX_PATTERN-1:0] hit;
    logic                   match;

    // Clamp the length into 1..MAX_PATTERN.
    always_comb
    begin
        len_raw = LW'(cfg.length);
        if (len_raw == '0)
        begin
            len_raw = LW'(1);
        end
        else if (len_raw > LW'(MAX_PATTERN))
        begin
            len_raw = LW'(MAX_PATTERN);
        end
        len = len_raw[CNT_W-1:0];
    end

    // Window with the new byte placed after the held ones, compared lane by lane.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            app[i] = (CNT_W'(i) == count_reg) ? item.data_byte : win_reg[i];
            hit[i] = (i >= int'(len)) || (app[i] == pattern_byte(cfg, i));
        end
        match = &hit;
    end

    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        flush_next = flush_reg;
        consume    = 1'b0;
        emit.valid = 1'b0;
        emit.data  = win_reg[0];
        emit.last  = 1'b0;

        if (flush_reg)
        begin
            // Drain the window after a stream end, one byte per cycle while the output register is free.
            if (out_free)
            begin
                emit.valid = 1'b1;
                emit.last  = (count_reg == CNT_W'(1));
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    flush_next = 1'b0;
                end
            end
        end
        else if (item_valid)
        begin
            if (count_reg >= len)
            begin
                // Length was lowered: pass surplus oldest bytes out unchanged first.
                if (out_free)
                begin
                    emit.valid = 1'b1;
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            else if ((count_reg + CNT_W'(1)) == len)
            begin
                // Window fills: compare, overwrite on a match, emit the oldest.
                if (out_free)
                begin
                    consume    = 1'b1;
                    emit.valid = 1'b1;
                    emit.data  = match ? cfg.fill : app[0];
                    emit.last  = item.end_of_stream && (len == CNT_W'(1));
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                    begin
                        win_next[i] = (match && ((i + 1) < int'(len))) ? cfg.fill : app[i + 1];
                    end
                    count_next = len - CNT_W'(1);
                    flush_next = item.end_of_stream && (len != CNT_W'(1));
                end
            end
            else
            begin
                // Window still short: just hold the byte.
                consume    = 1'b1;
                win_next   = app;
                count_next = count_reg + CNT_W'(1);
                flush_next = item.end_of_stream;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flush_reg <= flush_next;
        end
    end

endmodule

FILE: rtl/bps_checker.sv
// Port-level checks of the byte pattern scrubber, bound to the top level.
`timescale 1ns / 1ps

module bps_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_eos,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);
    logic       in_beat;
    logic       out_beat;
    logic [7:0] held_reg;
    logic [2:0] eos_cnt_reg;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Track bytes taken but not yet delivered, and stream ends not yet closed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            eos_cnt_reg <= '0;
        end
        else
        begin
            held_reg    <= held_reg + 8'(in_beat) - 8'(out_beat);
            eos_cnt_reg <= eos_cnt_reg + 3'(in_beat && in_eos) - 3'(out_beat && out_last);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("egress beat changed while stalled");

    a_no_invented_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> held_reg != 8'd0)
        else $error("egress beat with no byte held");

    a_last_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && out_last |-> eos_cnt_reg != 3'd0)
        else $error("final byte flagged without a stream end");

    a_ends_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        eos_cnt_reg != 3'd4 && eos_cnt_reg != 3'd5 && eos_cnt_reg != 3'd6
        && eos_cnt_reg != 3'd7)
        else $error("stream ends pile up without final bytes");

endmodule

bind byte_pattern_scrubber_unit bps_checker u_bps_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ingress.valid),
    .in_ready  (ingress.ready),
    .in_eos    (ingress.end_of_stream),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .out_byte  (egress.out_byte),
    .out_last  (egress.out_last)
);

FILE: verif/byte_scrub_checker.sv
// Watches the scrubber channels, predicts each scrubbed byte and compares it with egress.
`timescale 1ns / 1ps

module byte_scrub_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    bps_in_if                               ingress,
    bps_out_if                              egress,
    output int                              fail_count,
    output int                              pending,
    output int                              beats_in,
    output int                              bytes_out,
    output int                              replacements
);
    import bps_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } scrubbed_t;

    scrubbed_t         due_bytes[$];
    cfg_t              regs;
    logic [BYTE_W-1:0] window [PATTERN_BYTES];
    int                held;

    function automatic int active_length();
        int len;
        len = int'(regs.length);
        if (len == 0) len = 1;
        if (len > PATTERN_BYTES) len = PATTERN_BYTES;
        return len;
    endfunction

    // Pop the oldest window byte onto the list of bytes due on egress.
    function automatic void release_oldest(input logic last);
        scrubbed_t s;
        int        i;
        s.value = window[0];
        s.last  = last;
        for (i = 0; i < PATTERN_BYTES - 1; i++) window[i] = window[i + 1];
        window[PATTERN_BYTES - 1] = BYTE_ZERO;
        held--;
        due_bytes.push_back(s);
    endfunction

    function automatic void scrub(input logic [BYTE_W-1:0] b, input logic eos);
        int                              len;
        int                              i;
        logic                            hit;
        logic [PATTERN_BYTES*BYTE_W-1:0] pat;
        len = active_length();
        pat = {regs.pattern_high, regs.pattern_mid, regs.pattern_low};
        window[held] = b;
        held++;
        // surplus after a shorter length was written goes out untouched
        while (held > len) release_oldest(1'b0);
        if (held == len) begin
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
                if (window[i] != pat[i*BYTE_W +: BYTE_W]) hit = 1'b0;
            end
            if (hit) begin
                replacements++;
                for (i = 0; i < len; i++) window[i] = regs.fill;
            end
            release_oldest(eos && held == 1);
        end
        if (eos) begin
            while (held > 0) release_oldest(held == 1);
        end
    endfunction

    function automatic void clear_model();
        int i;
        regs.pattern_low  = '0;
        regs.pattern_mid  = '0;
        regs.pattern_high = '0;
        regs.length       = LENGTH_RESET;
        regs.fill         = BYTE_ZERO;
        for (i = 0; i < PATTERN_BYTES; i++) window[i] = BYTE_ZERO;
        held = 0;
        due_bytes.delete();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scrubbed_t want;
        if (!rst_n)
        begin
            clear_model();
            fail_count   = 0;
            pending      = 0;
            beats_in     = 0;
            bytes_out    = 0;
            replacements = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_LOW:  regs.pattern_low  = cfg_data;
                    REG_PATTERN_MID:  regs.pattern_mid  = cfg_data;
                    REG_PATTERN_HIGH: regs.pattern_high = cfg_data;
                    REG_LENGTH:       regs.length       = cfg_data[LENGTH_W-1:0];
                    REG_FILL:         regs.fill         = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (ingress.valid && ingress.ready)
            begin
                beats_in++;
                scrub(ingress.data_byte, ingress.end_of_stream);
            end
            if (egress.valid && egress.ready)
            begin
                bytes_out++;
                if (due_bytes.size() == 0)
                begin
                    $error("unexpected egress beat: out_byte 0x%02h out_last %0b",
                           egress.out_byte, egress.out_last);
                    fail_count++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (egress.out_byte !== want.value)
                    begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.value, egress.out_byte);
                        fail_count++;
                    end
                    if (egress.out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, actual %0b",
                               want.last, egress.out_last);
                        fail_count++;
                    end
                end
            end
            pending = due_bytes.size();
        end
    end

endmodule

FILE: verif/byte_pattern_scrubber_unit_tb.sv
// Top of the scrubber testbench: clock, reset, register writes, byte streams and verdict.
`timescale 1ns / 1ps

module byte_pattern_scrubber_unit_tb;
    import bps_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;     // margin for the last beat to leave the input stage and output register
    localparam int END_SETTLE   = 40;    // covers a full 23-byte flush with room to spare
    localparam int QUIET_LIMIT  = 2000;  // cycles without any beat before giving up
    localparam int PHASES       = 12;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Idle rates in percent, changed per phase group.
    int src_idle_pct  = 16;
    int sink_idle_pct = 49;
    int settings_used = 0;
    int quiet_cycles  = 0;

    int fail_count;
    int pending;
    int beats_in;
    int bytes_out;
    int replacements;

    // Current pattern and fill, kept here only to shape the streams.
    logic [WORD_W-1:0] pat_lo;
    logic [WORD_W-1:0] pat_mid;
    logic [WORD_W-1:0] pat_hi;
    logic [BYTE_W-1:0] cur_fill;
    int                cur_len;

    // Length written per random phase: both ends of the legal range, the zero
    // value that acts as one, and the oversize value that acts as the maximum.
    int phase_len [PHASES] = '{1, 24, 0, 31, 3, 8, 2, 16, 24, 5, 12, 7};

    bps_in_if  ingress();
    bps_out_if egress();

    byte_pattern_scrubber_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ingress   (ingress),
        .egress    (egress)
    );

    byte_scrub_checker scrub_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ingress      (ingress),
        .egress       (egress),
        .fail_count   (fail_count),
        .pending      (pending),
        .beats_in     (beats_in),
        .bytes_out    (bytes_out),
        .replacements (replacements)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Receiver: drop ready at random on the falling edge, per the current idle rate.
    always @(negedge clk)
    begin
        egress.ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ingress.valid && ingress.ready) || (egress.valid && egress.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] pattern_at(input int i);
        logic [PATTERN_BYTES*BYTE_W-1:0] all_bits;
        all_bits = {pat_hi, pat_mid, pat_lo};
        return all_bits[i*BYTE_W +: BYTE_W];
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Drive one beat from a falling edge; may idle first. Leave valid high on
    // return so the next call (or a park) decides its value at that same edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            ingress.valid = 1'b0;
            @(negedge clk);
        end
        ingress.valid         = 1'b1;
        ingress.data_byte     = b;
        ingress.end_of_stream = eos;
        @(posedge clk);
        while (!ingress.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Park the sender, then hold until every predicted byte has come out and the
    // last beat has surely left the pipeline.
    task automatic drain();
        ingress.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
    endtask

    // Write all five registers while idle. Upper bits of the length and fill
    // words carry noise; only the low bits of each may count.
    task automatic apply_setting(input logic [WORD_W-1:0] lo,
                                 input logic [WORD_W-1:0] mid,
                                 input logic [WORD_W-1:0] hi,
                                 input int len,
                                 input logic [BYTE_W-1:0] fill);
        logic [CFG_DATA_W-1:0] word;
        drain();
        pat_lo   = lo;
        pat_mid  = mid;
        pat_hi   = hi;
        cur_fill = fill;
        cur_len  = (len == 0) ? 1 : (len > PATTERN_BYTES) ? PATTERN_BYTES : len;
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_MID, mid);
        write_reg(REG_PATTERN_HIGH, hi);
        word = rand_word();
        word[LENGTH_W-1:0] = len[LENGTH_W-1:0];
        write_reg(REG_LENGTH, word);
        word = rand_word();
        word[BYTE_W-1:0] = fill;
        write_reg(REG_FILL, word);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    // Build one stream mostly from pattern copies and prefixes, with pattern
    // bytes, fill bytes and raw noise mixed in, then send it. The last stream
    // of a phase may be left open so the next length write meets a held window.
    task automatic send_stream(input int budget_left, input bit may_stay_open,
                               output int sent);
        logic [BYTE_W-1:0] seq[$];
        int                target;
        int                r;
        int                k;
        int                n;
        logic              leave_open;
        target = $urandom_range(1, 2 * cur_len + 2);
        while (seq.size() < target)
        begin
            r = $urandom_range(0, 9);
            if (r <= 3)
            begin
                for (k = 0; k < cur_len; k++) seq.push_back(pattern_at(k));
            end
            else if (r == 4)
            begin
                n = $urandom_range(1, cur_len);
                for (k = 0; k < n; k++) seq.push_back(pattern_at(k));
            end
            else if (r <= 6)
                seq.push_back(pattern_at($urandom_range(0, cur_len - 1)));
            else if (r == 7)
                seq.push_back(cur_fill);
            else
                seq.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        leave_open = may_stay_open && (seq.size() >= budget_left)
                     && ($urandom_range(0, 1) == 1);
        for (k = 0; k < seq.size(); k++)
            send_byte(seq[k], !leave_open && (k == seq.size() - 1));
        sent = seq.size();
    endtask

    initial
    begin
        int                p;
        int                phase_items;
        int                sent;
        logic [WORD_W-1:0] w;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_PATTERN_LOW;
        cfg_data              = '0;
        ingress.valid         = 1'b0;
        ingress.data_byte     = BYTE_ZERO;
        ingress.end_of_stream = 1'b0;
        egress.ready          = 1'b0;
        pat_lo                = '0;
        pat_mid               = '0;
        pat_hi                = '0;
        cur_fill              = BYTE_ZERO;
        cur_len               = 1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: length one, zero pattern, zero fill. Byte extremes.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // Length zero behaves as length one.
        w = rand_word();
        w[7:0] = 8'hA5;
        apply_setting(w, rand_word(), rand_word(), 0, 8'h5A);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'hA5, 1'b1);

        // Four-byte pattern holding both byte extremes: a full match, then a
        // short stream whose window never fills and so is never compared.
        w[31:0] = 32'hFF003CA5;
        apply_setting(w, rand_word(), rand_word(), 4, 8'hC3);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b1);

        // Length lowered with three bytes held: surplus leaves before the compare.
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        apply_setting(pat_lo, pat_mid, pat_hi, 2, cur_fill);
        send_byte(8'h44, 1'b1);

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        for (p = 0; p < PHASES; p++)
        begin
            case (p / 4)
                0:       begin src_idle_pct = 16; sink_idle_pct = 49; end
                1:       begin src_idle_pct = 49; sink_idle_pct = 16; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            if (p == 3)
                apply_setting('1, '1, '1, phase_len[p], 8'hFF);
            else if (p == 6)
                apply_setting('0, '0, '0, phase_len[p], 8'hFF);
            else
                apply_setting(rand_word(), rand_word(), rand_word(), phase_len[p],
                              (p % 4 == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255)));
            phase_items = 0;
            while (phase_items < 16 + cur_len)
            begin
                send_stream(16 + cur_len - phase_items, p != PHASES - 1, sent);
                phase_items += sent;
            end
        end

        // Park the sender and let every outstanding byte come out.
        ingress.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (END_SETTLE) @(negedge clk);

        $display("Run covered %0d ingress beats under %0d register settings,",
                 beats_in, settings_used);
        $display("%0d pattern replacements and %0d scrubbed bytes compared.",
                 replacements, bytes_out);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
        begin
            if (pending != 0)
                $error("%0d scrubbed bytes never arrived", pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bps_pkg.sv
rtl/bps_if.sv
rtl/bps_cfg_regs.sv
rtl/bps_window.sv
rtl/byte_pattern_scrubber_unit.sv
rtl/bps_checker.sv
verif/byte_scrub_checker.sv
verif/byte_pattern_scrubber_unit_tb.sv
